### src/cutk_pkg.sv
// ----------------------------------------------------------------------------
// cutk_pkg
// Shared types, constants and decode functions of the Cyrillic key tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package cutk_pkg;

	localparam int unsigned MAX_SYMBOLS_DEF = 255;
	localparam logic [7:0]  LIMIT_RESET     = 8'hFF;

	localparam logic [7:0] LEAD_BYTE_D0 = 8'hD0;
	localparam logic [7:0] LEAD_BYTE_D1 = 8'hD1;
	localparam logic [7:0] BYTE_NUL     = 8'h00;
	localparam logic [7:0] BYTE_DASH    = 8'h2D;
	localparam logic [7:0] BYTE_USCORE  = 8'h5F;
	localparam logic [7:0] BYTE_DOT     = 8'h2E;
	localparam logic [7:0] BYTE_ZERO    = 8'h30;
	localparam logic [7:0] BYTE_NINE    = 8'h39;
	localparam logic [7:0] BYTE_YO_D0   = 8'h81;
	localparam logic [7:0] BYTE_YO_D1   = 8'h91;

	localparam logic [5:0] SYM_NONE   = 6'd0;
	localparam logic [5:0] SYM_YO     = 6'd33;
	localparam logic [5:0] SYM_DASH   = 6'd34;
	localparam logic [5:0] SYM_USCORE = 6'd35;
	localparam logic [5:0] SYM_DOT    = 6'd36;
	localparam logic [5:0] SYM_DIGIT0 = 6'd37;
	localparam logic [5:0] SYM_LAST   = 6'd46;

	localparam logic [5:0] TAB_FIRST_HALF [16] = '{
		6'd3, 6'd21, 6'd9, 6'd19, 6'd13, 6'd2, 6'd25, 6'd20,
		6'd4, 6'd23, 6'd11, 6'd10, 6'd12, 6'd5, 6'd1, 6'd14
	};
	localparam logic [5:0] TAB_SECOND_HALF [16] = '{
		6'd8, 6'd7, 6'd6, 6'd15, 6'd31, 6'd24, 6'd28, 6'd22,
		6'd26, 6'd29, 6'd32, 6'd17, 6'd18, 6'd30, 6'd27, 6'd16
	};

	typedef enum logic [1:0] {
		LEAD_NONE = 2'd0,
		LEAD_D0   = 2'd1,
		LEAD_D1   = 2'd2
	} lead_t;

	typedef enum logic [1:0] {
		CAUSE_NUL      = 2'd0,
		CAUSE_UNMAPPED = 2'd1,
		CAUSE_LIMIT    = 2'd2
	} cause_t;

	typedef struct packed {
		lead_t      pending_lead;
		logic [7:0] byte_index;
		logic [7:0] symbols_made;
		logic       key_stopped;
	} state_t;

	localparam state_t STATE_ARMED = '{
		pending_lead: LEAD_NONE, byte_index: 8'd0, symbols_made: 8'd0, key_stopped: 1'b0
	};

	typedef struct packed {
		logic       symbol_valid;
		logic [5:0] symbol;
		logic       key_done;
		logic [7:0] symbol_count;
		logic [5:0] size_class;
		logic [6:0] header_word;
		logic [7:0] bytes_used;
		cause_t     stop_cause;
	} result_t;

	function automatic logic [5:0] map_single(input logic [7:0] b);
		logic [7:0] ofs;
		ofs = b - BYTE_ZERO;
		if (b == BYTE_DASH)
			return SYM_DASH;
		else if (b == BYTE_USCORE)
			return SYM_USCORE;
		else if (b == BYTE_DOT)
			return SYM_DOT;
		else if (b >= BYTE_ZERO && b <= BYTE_NINE)
			return SYM_DIGIT0 + ofs[5:0];
		else
			return SYM_NONE;
	endfunction

	function automatic logic [5:0] map_pair(input lead_t lead, input logic [7:0] b);
		if (lead == LEAD_D0) begin
			if (b == BYTE_YO_D0)
				return SYM_YO;
			else if (b[7:4] == 4'h9 || b[7:4] == 4'hB)
				return TAB_FIRST_HALF[b[3:0]];
			else if (b[7:4] == 4'hA)
				return TAB_SECOND_HALF[b[3:0]];
			else
				return SYM_NONE;
		end else begin
			if (b[7:4] == 4'h8)
				return TAB_SECOND_HALF[b[3:0]];
			else if (b == BYTE_YO_D1)
				return SYM_YO;
			else
				return SYM_NONE;
		end
	endfunction

	// (count + 1) / 5 by reciprocal 205/1024, exact for count up to 255
	function automatic logic [5:0] size_class_of(input logic [7:0] count);
		logic [8:0]  n;
		logic [16:0] p;
		n = {1'b0, count} + 9'd1;
		p = 17'(n) * 17'd205;
		return p[15:10];
	endfunction

endpackage

`default_nettype wire

### src/cutk_if.sv
// ----------------------------------------------------------------------------
// cutk_if
// Valid/ready channels of the key tokenizer: key bytes in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cutk_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_buffer;

	modport source(output valid, output in_byte, output end_of_buffer, input ready);
	modport sink(input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface cutk_out_if;
	logic       valid;
	logic       ready;
	logic       symbol_valid;
	logic [5:0] symbol;
	logic       key_done;
	logic [7:0] symbol_count;
	logic [5:0] size_class;
	logic [6:0] header_word;
	logic [7:0] bytes_used;
	logic [1:0] stop_cause;

	modport source(
		output valid, output symbol_valid, output symbol, output key_done,
		output symbol_count, output size_class, output header_word,
		output bytes_used, output stop_cause, input ready
	);
	modport sink(
		input valid, input symbol_valid, input symbol, input key_done,
		input symbol_count, input size_class, input header_word,
		input bytes_used, input stop_cause, output ready
	);
endinterface

`default_nettype wire

### src/cutk_step.sv
// ----------------------------------------------------------------------------
// cutk_step
// Per-byte decode: next key state and the result, if any, for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cutk_step #(
	parameter int unsigned MAX_SYMBOLS = cutk_pkg::MAX_SYMBOLS_DEF
) (
	input  cutk_pkg::state_t  st,
	input  logic [7:0]        in_byte,
	input  logic              end_of_buffer,
	input  logic [7:0]        limit,
	output cutk_pkg::state_t  nxt,
	output logic              res_valid,
	output cutk_pkg::result_t res
);

	localparam logic [7:0] SYM_CAP = 8'(MAX_SYMBOLS);

	logic            sv;
	logic            done;
	logic [5:0]      sym;
	cutk_pkg::cause_t cause;
	logic [7:0]      used;
	logic [7:0]      bi;
	logic [7:0]      sm;
	cutk_pkg::lead_t lead;
	logic [5:0]      cls;

	always_comb begin
		sv    = 1'b0;
		done  = 1'b0;
		sym   = cutk_pkg::SYM_NONE;
		cause = cutk_pkg::CAUSE_NUL;
		used  = 8'd0;
		bi    = st.byte_index;
		sm    = st.symbols_made;
		lead  = st.pending_lead;
		nxt   = st;

		if (st.key_stopped) begin
			if (end_of_buffer)
				nxt = cutk_pkg::STATE_ARMED;
		end else begin
			if (st.pending_lead == cutk_pkg::LEAD_NONE) begin
				if (bi >= limit) begin
					done  = 1'b1;
					cause = cutk_pkg::CAUSE_LIMIT;
					used  = bi;
				end else if (in_byte == cutk_pkg::BYTE_NUL) begin
					done  = 1'b1;
					cause = cutk_pkg::CAUSE_NUL;
					used  = bi;
				end else if (in_byte == cutk_pkg::LEAD_BYTE_D0 ||
						in_byte == cutk_pkg::LEAD_BYTE_D1) begin
					if (({1'b0, bi} + 9'd1 >= {1'b0, limit}) || end_of_buffer) begin
						done  = 1'b1;
						cause = cutk_pkg::CAUSE_LIMIT;
						used  = bi;
					end else begin
						lead = (in_byte == cutk_pkg::LEAD_BYTE_D0) ?
							cutk_pkg::LEAD_D0 : cutk_pkg::LEAD_D1;
						bi   = bi + 8'd1;
					end
				end else begin
					sym = cutk_pkg::map_single(in_byte);
					if (sym == cutk_pkg::SYM_NONE) begin
						done  = 1'b1;
						cause = cutk_pkg::CAUSE_UNMAPPED;
						used  = bi;
					end else begin
						sv = 1'b1;
						sm = sm + 8'd1;
						bi = bi + 8'd1;
					end
				end
			end else begin
				sym  = cutk_pkg::map_pair(st.pending_lead, in_byte);
				lead = cutk_pkg::LEAD_NONE;
				if (sym == cutk_pkg::SYM_NONE) begin
					done  = 1'b1;
					cause = cutk_pkg::CAUSE_UNMAPPED;
					used  = bi;
				end else begin
					sv = 1'b1;
					sm = sm + 8'd1;
					bi = bi + 8'd1;
				end
			end

			if (!done && (end_of_buffer || bi >= limit || sm >= SYM_CAP)) begin
				done  = 1'b1;
				cause = cutk_pkg::CAUSE_LIMIT;
				used  = bi;
			end

			nxt.pending_lead = lead;
			nxt.byte_index   = bi;
			nxt.symbols_made = sm;
			if (done) begin
				if (end_of_buffer)
					nxt = cutk_pkg::STATE_ARMED;
				else
					nxt.key_stopped = 1'b1;
			end
		end
	end

	assign cls       = cutk_pkg::size_class_of(sm);
	assign res_valid = sv || done;

	always_comb begin
		res              = '0;
		res.symbol_valid = sv;
		res.symbol       = sv ? sym : cutk_pkg::SYM_NONE;
		res.key_done     = done;
		if (done) begin
			res.symbol_count = sm;
			res.size_class   = cls;
			res.header_word  = {cls, 1'b1};
			res.bytes_used   = used;
			res.stop_cause   = cause;
		end
	end

endmodule

`default_nettype wire

### src/cyrillic_utf8_key_tokenizer.sv
// ----------------------------------------------------------------------------
// cyrillic_utf8_key_tokenizer
// Turns a byte stream of key text into Cyrillic/ASCII symbol codes and a
// per-key summary (count, size class, header word, bytes used, stop cause).
//
//   channel   dir   modport  beat carries
//   key_in    in    sink     in_byte, end_of_buffer
//   tok_out   out   source   symbol fields and key summary
//   cfg_we    in    -        max_source_bytes write (cfg_wdata)
//
// One byte per clock sustained while tok_out keeps taking results; a key_in
// beat reaches tok_out through the input register, then the decode into the
// result register. A byte that yields no result leaves no beat on tok_out.
// key_in stays ready while the result register is taken or empty; a stalled
// result holds only the input register behind it.
// arst_n clears key state and sets the byte limit to 255.
// ----------------------------------------------------------------------------
`default_nettype none

module cyrillic_utf8_key_tokenizer #(
	parameter int unsigned MAX_SYMBOLS = cutk_pkg::MAX_SYMBOLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	cutk_in_if.sink           key_in,
	cutk_out_if.source        tok_out
);

	logic [7:0]        limit_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              eob_s1;
	cutk_pkg::state_t  st_q;
	cutk_pkg::state_t  st_nxt;
	logic              out_valid_q;
	cutk_pkg::result_t res_q;
	cutk_pkg::result_t res_nxt;
	logic              res_valid;
	logic              advance;

	assign advance      = !out_valid_q || tok_out.ready;
	assign key_in.ready = arst_n && (!valid_s1 || advance);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= cutk_pkg::LIMIT_RESET;
		else if (cfg_we)
			limit_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (key_in.ready)
			valid_s1 <= key_in.valid;
	end

	always_ff @(posedge clk) begin
		if (key_in.ready && key_in.valid) begin
			byte_s1 <= key_in.in_byte;
			eob_s1  <= key_in.end_of_buffer;
		end
	end

	cutk_step #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_step (
		.st           (st_q),
		.in_byte      (byte_s1),
		.end_of_buffer(eob_s1),
		.limit        (limit_q),
		.nxt          (st_nxt),
		.res_valid    (res_valid),
		.res          (res_nxt)
	);

	// advance key state and load the result when the stage moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= cutk_pkg::STATE_ARMED;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
			if (valid_s1)
				st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid)
			res_q <= res_nxt;
	end

	assign tok_out.valid        = out_valid_q;
	assign tok_out.symbol_valid = res_q.symbol_valid;
	assign tok_out.symbol       = res_q.symbol;
	assign tok_out.key_done     = res_q.key_done;
	assign tok_out.symbol_count = res_q.symbol_count;
	assign tok_out.size_class   = res_q.size_class;
	assign tok_out.header_word  = res_q.header_word;
	assign tok_out.bytes_used   = res_q.bytes_used;
	assign tok_out.stop_cause   = res_q.stop_cause;

	a_pending_has_lead: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.pending_lead != cutk_pkg::LEAD_NONE |-> st_q.byte_index != 8'd0)
		else $error("pending lead with no byte consumed");

	a_count_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.key_done |-> res_q.symbol_count <= res_q.bytes_used)
		else $error("symbol count exceeds bytes used");

	a_symbol_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.symbol_valid |->
			res_q.symbol != cutk_pkg::SYM_NONE && res_q.symbol <= cutk_pkg::SYM_LAST)
		else $error("symbol code out of range");

	a_header_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.key_done |-> res_q.header_word == {res_q.size_class, 1'b1})
		else $error("header word does not match size class");

	a_beat_has_content: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.symbol_valid || res_q.key_done)
		else $error("empty result beat");

endmodule

`default_nettype wire

### tb/cyrillic_utf8_key_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// cyrillic_utf8_key_tokenizer_tb
// Checks the key tokenizer one beat at a time against a behavioral predictor.
// A short table of directed bytes and limit writes is run first. Random keys
// follow, mostly well-formed Cyrillic and ASCII text with random endings, under
// several byte limits. The sender idles in bursts and the result side stalls
// on its own pattern, with one long hold-off that backs up the input.
// ----------------------------------------------------------------------------

module cyrillic_utf8_key_tokenizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cutk_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int TOKEN_CAP       = MAX_SYMBOLS_DEF;
	localparam int SETTLE_CYCLES   = 4;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int NUM_PHASES      = 8;
	localparam int PHASE_BYTES     = 120;
	localparam int NUM_ROWS        = 29;

	localparam int FOLD_A [16] = '{3, 21, 9, 19, 13, 2, 25, 20, 4, 23, 11, 10, 12, 5, 1, 14};
	localparam int FOLD_B [16] = '{8, 7, 6, 15, 31, 24, 28, 22, 26, 29, 32, 17, 18, 30, 27, 16};

	localparam result_t NO_PIN = '0;

	typedef struct packed {
		logic       is_cfg;
		logic [7:0] value;
		logic       eob;
		logic       pin;
		result_t    want;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	cutk_in_if  key_in();
	cutk_out_if tok_out();

	cyrillic_utf8_key_tokenizer #(
		.MAX_SYMBOLS(TOKEN_CAP)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.key_in   (key_in),
		.tok_out  (tok_out)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	lead_t   lead_now;
	int      bytes_in_key;
	int      syms_in_key;
	logic    key_halted;
	int      byte_limit;
	logic    key_over;
	result_t queued_tokens[$];
	int      bytes_taken;
	int      burst_left;
	int      mismatches;
	int      quiet_cycles;
	logic    hold_off_req;

	stim_row_t stim_rows [NUM_ROWS];

	function automatic int plain_code(input logic [7:0] b);
		case (b)
			BYTE_DASH:   return 34;
			BYTE_USCORE: return 35;
			BYTE_DOT:    return 36;
			default: begin
				if (b >= BYTE_ZERO && b <= BYTE_NINE)
					return 37 + int'(b - BYTE_ZERO);
				return 0;
			end
		endcase
	endfunction

	function automatic int letter_code(input lead_t lead, input logic [7:0] b);
		if (lead == LEAD_D0) begin
			if (b == BYTE_YO_D0)
				return 33;
			if ((b >= 8'h90 && b <= 8'h9F) || (b >= 8'hB0 && b <= 8'hBF))
				return FOLD_A[b & 8'h0F];
			if (b >= 8'hA0 && b <= 8'hAF)
				return FOLD_B[b & 8'h0F];
			return 0;
		end
		if (b >= 8'h80 && b <= 8'h8F)
			return FOLD_B[b & 8'h0F];
		if (b == BYTE_YO_D1)
			return 33;
		return 0;
	endfunction

	function automatic stim_row_t beat_row(input logic [7:0] b, input logic eob);
		stim_row_t r;
		r = '0;
		r.value = b;
		r.eob = eob;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [7:0] v);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.value = v;
		return r;
	endfunction

	function automatic stim_row_t pinned_row(input logic [7:0] b, input logic eob,
			input logic sv, input logic [5:0] sym, input logic done,
			input logic [7:0] cnt, input logic [5:0] cls, input logic [6:0] hdr,
			input logic [7:0] used, input cause_t why);
		stim_row_t r;
		r = beat_row(b, eob);
		r.pin = 1'b1;
		r.want.symbol_valid = sv;
		r.want.symbol = sym;
		r.want.key_done = done;
		r.want.symbol_count = cnt;
		r.want.size_class = cls;
		r.want.header_word = hdr;
		r.want.bytes_used = used;
		r.want.stop_cause = why;
		return r;
	endfunction

	task automatic rearm_key();
		lead_now = LEAD_NONE;
		bytes_in_key = 0;
		syms_in_key = 0;
		key_halted = 1'b0;
	endtask

	task automatic tokenize_byte(input logic [7:0] b, input logic eob,
			output logic has_tok, output result_t tok);
		int     sym;
		int     used;
		int     cls;
		logic   sv;
		logic   done;
		cause_t why;
		sym = 0;
		used = 0;
		sv = 1'b0;
		done = 1'b0;
		why = CAUSE_NUL;
		has_tok = 1'b0;
		tok = '0;
		if (key_halted) begin
			if (eob)
				rearm_key();
			return;
		end
		if (lead_now == LEAD_NONE) begin
			if (bytes_in_key >= byte_limit) begin
				done = 1'b1;
				why = CAUSE_LIMIT;
				used = bytes_in_key;
			end else if (b == BYTE_NUL) begin
				done = 1'b1;
				why = CAUSE_NUL;
				used = bytes_in_key;
			end else if (b == LEAD_BYTE_D0 || b == LEAD_BYTE_D1) begin
				if (bytes_in_key + 1 >= byte_limit || eob) begin
					done = 1'b1;
					why = CAUSE_LIMIT;
					used = bytes_in_key;
				end else begin
					lead_now = (b == LEAD_BYTE_D0) ? LEAD_D0 : LEAD_D1;
					bytes_in_key++;
				end
			end else begin
				sym = plain_code(b);
				if (sym == 0) begin
					done = 1'b1;
					why = CAUSE_UNMAPPED;
					used = bytes_in_key;
				end else begin
					sv = 1'b1;
					syms_in_key++;
					bytes_in_key++;
				end
			end
		end else begin
			sym = letter_code(lead_now, b);
			lead_now = LEAD_NONE;
			if (sym == 0) begin
				done = 1'b1;
				why = CAUSE_UNMAPPED;
				used = bytes_in_key;
			end else begin
				sv = 1'b1;
				syms_in_key++;
				bytes_in_key++;
			end
		end
		if (!done && (eob || bytes_in_key >= byte_limit || syms_in_key >= TOKEN_CAP)) begin
			done = 1'b1;
			why = CAUSE_LIMIT;
			used = bytes_in_key;
		end
		if (!sv && !done)
			return;
		has_tok = 1'b1;
		tok.symbol_valid = sv;
		tok.symbol = sv ? 6'(sym) : 6'd0;
		tok.key_done = done;
		if (done) begin
			cls = (syms_in_key + 1) / 5;
			tok.symbol_count = 8'(syms_in_key);
			tok.size_class = 6'(cls);
			tok.header_word = 7'(1 + 2 * cls);
			tok.bytes_used = 8'(used);
			tok.stop_cause = why;
			key_over = 1'b1;
			if (eob)
				rearm_key();
			else
				key_halted = 1'b1;
		end
	endtask

	task automatic offer_byte(input logic [7:0] b, input logic eob, input logic pin,
			input result_t pinned);
		result_t tok;
		logic    has_tok;
		int      gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				key_in.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		key_in.valid <= 1'b1;
		key_in.in_byte <= b;
		key_in.end_of_buffer <= eob;
		@(posedge clk);
		while (!key_in.ready)
			@(posedge clk);
		burst_left--;
		tokenize_byte(b, eob, has_tok, tok);
		if (pin)
			queued_tokens.push_back(pinned);
		else if (has_tok)
			queued_tokens.push_back(tok);
		bytes_taken++;
	endtask

	task automatic settle_block();
		@(negedge clk);
		key_in.valid <= 1'b0;
		burst_left = 0;
		while (queued_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_byte_limit(input logic [7:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		byte_limit = v;
	endtask

	task automatic send_key(input int n_chars);
		int         i;
		int         pick;
		int         k;
		logic       last;
		logic [7:0] lead_b;
		logic [7:0] second_b;
		key_over = 1'b0;
		for (i = 0; i < n_chars && !key_over; i++) begin
			last = (i == n_chars - 1) && ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 9) begin
				k = $urandom_range(0, 12);
				offer_byte(k == 0 ? BYTE_DASH : k == 1 ? BYTE_USCORE : k == 2 ? BYTE_DOT :
					BYTE_ZERO + 8'(k - 3), last, 1'b0, NO_PIN);
			end else if (pick < 17) begin
				lead_b = $urandom_range(0, 1) ? LEAD_BYTE_D1 : LEAD_BYTE_D0;
				if (pick == 16)
					second_b = 8'($urandom_range(0, 255));
				else if (lead_b == LEAD_BYTE_D0)
					second_b = ($urandom_range(0, 15) == 0) ? BYTE_YO_D0 :
						8'h90 + 8'($urandom_range(0, 47));
				else
					second_b = ($urandom_range(0, 16) == 0) ? BYTE_YO_D1 :
						8'h80 + 8'($urandom_range(0, 15));
				offer_byte(lead_b, 1'b0, 1'b0, NO_PIN);
				if (!key_over)
					offer_byte(second_b, last, 1'b0, NO_PIN);
			end else begin
				offer_byte(8'($urandom_range(0, 255)), last, 1'b0, NO_PIN);
			end
		end
		while (!key_over) begin
			case ($urandom_range(0, 2))
				0:       offer_byte(BYTE_NUL, 1'($urandom_range(0, 1)), 1'b0, NO_PIN);
				1:       offer_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_PIN);
				default: offer_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_PIN);
			endcase
		end
		if (key_halted) begin
			repeat ($urandom_range(0, 3))
				offer_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_PIN);
			offer_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_PIN);
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : token_check
		result_t want;
		if (arst_n && tok_out.valid && tok_out.ready) begin
			if (queued_tokens.size() == 0) begin
				$error("result beat with nothing expected: symbol %0d, done %0b",
					tok_out.symbol, tok_out.key_done);
				mismatches++;
			end else begin
				want = queued_tokens.pop_front();
				check_field("symbol_valid", want.symbol_valid, tok_out.symbol_valid);
				check_field("symbol", want.symbol, tok_out.symbol);
				check_field("key_done", want.key_done, tok_out.key_done);
				check_field("symbol_count", want.symbol_count, tok_out.symbol_count);
				check_field("size_class", want.size_class, tok_out.size_class);
				check_field("header_word", want.header_word, tok_out.header_word);
				check_field("bytes_used", want.bytes_used, tok_out.bytes_used);
				check_field("stop_cause", int'(want.stop_cause), tok_out.stop_cause);
			end
		end
	end

	always begin : token_ready_gen
		int mode;
		int span;
		int tick;
		@(negedge clk);
		if (hold_off_req) begin
			tok_out.ready <= 1'b0;
			repeat (HOLD_OFF_CYCLES) @(negedge clk);
			hold_off_req = 1'b0;
		end else begin
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(8, 64);
			end
			span--;
			tick++;
			case (mode)
				0:       tok_out.ready <= 1'b1;
				1:       tok_out.ready <= 1'($urandom_range(0, 1));
				2:       tok_out.ready <= ($urandom_range(0, 3) == 0);
				default: tok_out.ready <= (tick % 5) < 3;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((key_in.valid && key_in.ready) || (tok_out.valid && tok_out.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("cyrillic_utf8_key_tokenizer_tb failed");
				$finish;
			end
		end
	end

	initial begin
		int ph;
		int start;
		int lim;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		key_in.valid = 1'b0;
		key_in.in_byte = 8'd0;
		key_in.end_of_buffer = 1'b0;
		tok_out.ready = 1'b0;
		hold_off_req = 1'b0;
		mismatches = 0;
		quiet_cycles = 0;
		bytes_taken = 0;
		burst_left = 0;
		key_over = 1'b0;
		byte_limit = LIMIT_RESET;
		rearm_key();

		stim_rows = '{
			pinned_row(BYTE_NUL, 1'b0, 1'b0, 6'd0, 1'b1, 8'd0, 6'd0, 7'd1, 8'd0, CAUSE_NUL),
			beat_row(8'h41, 1'b1),
			pinned_row(BYTE_DASH, 1'b0, 1'b1, 6'd34, 1'b0, 8'd0, 6'd0, 7'd0, 8'd0, CAUSE_NUL),
			pinned_row(BYTE_USCORE, 1'b0, 1'b1, 6'd35, 1'b0, 8'd0, 6'd0, 7'd0, 8'd0, CAUSE_NUL),
			pinned_row(BYTE_DOT, 1'b0, 1'b1, 6'd36, 1'b0, 8'd0, 6'd0, 7'd0, 8'd0, CAUSE_NUL),
			pinned_row(BYTE_ZERO, 1'b0, 1'b1, 6'd37, 1'b0, 8'd0, 6'd0, 7'd0, 8'd0, CAUSE_NUL),
			pinned_row(BYTE_NINE, 1'b0, 1'b1, 6'd46, 1'b0, 8'd0, 6'd0, 7'd0, 8'd0, CAUSE_NUL),
			beat_row(LEAD_BYTE_D0, 1'b0),
			beat_row(BYTE_YO_D0, 1'b0),
			beat_row(LEAD_BYTE_D0, 1'b0),
			beat_row(8'h90, 1'b0),
			beat_row(LEAD_BYTE_D1, 1'b0),
			beat_row(8'h8F, 1'b0),
			beat_row(LEAD_BYTE_D1, 1'b0),
			beat_row(BYTE_YO_D1, 1'b0),
			beat_row(LEAD_BYTE_D0, 1'b0),
			beat_row(8'hFF, 1'b0),
			beat_row(8'hFF, 1'b1),
			pinned_row(LEAD_BYTE_D1, 1'b1, 1'b0, 6'd0, 1'b1, 8'd0, 6'd0, 7'd1, 8'd0,
				CAUSE_LIMIT),
			pinned_row(BYTE_NUL, 1'b1, 1'b0, 6'd0, 1'b1, 8'd0, 6'd0, 7'd1, 8'd0, CAUSE_NUL),
			pinned_row(8'h35, 1'b1, 1'b1, 6'd42, 1'b1, 8'd1, 6'd0, 7'd1, 8'd1, CAUSE_LIMIT),
			cfg_row(8'd0),
			pinned_row(BYTE_DASH, 1'b0, 1'b0, 6'd0, 1'b1, 8'd0, 6'd0, 7'd1, 8'd0, CAUSE_LIMIT),
			beat_row(8'h7F, 1'b1),
			cfg_row(8'd1),
			pinned_row(LEAD_BYTE_D0, 1'b0, 1'b0, 6'd0, 1'b1, 8'd0, 6'd0, 7'd1, 8'd0,
				CAUSE_LIMIT),
			beat_row(BYTE_NUL, 1'b1),
			pinned_row(8'h37, 1'b0, 1'b1, 6'd44, 1'b1, 8'd1, 6'd0, 7'd1, 8'd1, CAUSE_LIMIT),
			beat_row(8'h80, 1'b1)
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_rows[r]) begin
			if (stim_rows[r].is_cfg) begin
				settle_block();
				set_byte_limit(stim_rows[r].value);
			end else begin
				offer_byte(stim_rows[r].value, stim_rows[r].eob, stim_rows[r].pin,
					stim_rows[r].want);
			end
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			settle_block();
			case (ph)
				0:       lim = 255;
				1:       lim = 0;
				2:       lim = 1;
				3:       lim = 2;
				4:       lim = 255;
				default: lim = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) :
					$urandom_range(3, 24);
			endcase
			set_byte_limit(8'(lim));
			if (ph == 3)
				hold_off_req = 1'b1;
			start = bytes_taken;
			if (ph == 0)
				send_key(300);
			while (bytes_taken - start < PHASE_BYTES)
				send_key($urandom_range(0, 12));
		end

		settle_block();
		if (mismatches == 0)
			$display("cyrillic_utf8_key_tokenizer_tb passed");
		else
			$display("cyrillic_utf8_key_tokenizer_tb failed");
		$finish;
	end

endmodule
